### sv/ibfd_pkg.sv
`timescale 1ns / 1ps

package ibfd_pkg;

  // Field widths on the stream ports.
  localparam int FIELD_BITS     = 18;
  localparam int FUNC_BITS      = 3;
  localparam int IN_FIELD_BITS  = 3 * FIELD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 4 * FIELD_BITS + 3;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

  // Configuration port.
  localparam int REG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;
  localparam int TARGET_BITS   = 16;

  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_COUNT = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_STABLE_LIMIT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ON_DELTA     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_OFF_DELTA    = 3'd3;

  localparam logic [TARGET_BITS-1:0]   TARGET_COUNT_RESET = 16'd64;
  localparam logic [CFG_DATA_BITS-1:0] STABLE_LIMIT_RESET = 18'd256;
  localparam logic [CFG_DATA_BITS-1:0] ON_DELTA_RESET     = 18'd4096;
  localparam logic [CFG_DATA_BITS-1:0] OFF_DELTA_RESET    = 18'd2048;

  // Function codes carried on the input tuser.
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR     = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_CALIBRATE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_SEED      = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_TRACK     = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_DETECT    = 3'd4;

  // Follower shift amounts.
  localparam int BASE_SHIFT  = 4;
  localparam int NOISE_SHIFT = 3;

  // Control from the sequencer to the statistics and tracker unit.
  typedef struct packed {
    logic                 update;
    logic                 noise_step;
    logic [FUNC_BITS-1:0] func;
  } ibfd_trk_ctl_t;

endpackage

### sv/ibfd_div.sv
`timescale 1ns / 1ps

module ibfd_div #(
  parameter int DIVIDEND_BITS = 34,
  parameter int DIVISOR_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dsr;
  logic [CNT_BITS-1:0]      cnt;
  logic                     busy;
  logic [DIVISOR_BITS:0]    rem_sh;
  logic [DIVISOR_BITS:0]    rem_sub;
  logic                     fits;

  // One restoring step: bring in the next dividend bit and try the subtract.
  assign rem_sh  = {rem, quo[DIVIDEND_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = (rem_sh >= {1'b0, dsr});

  // Quotient bits shift in where dividend bits shift out, one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIVIDEND_BITS-2:0], fits};
        rem <= fits ? rem_sub[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### sv/ibfd_track.sv
`timescale 1ns / 1ps

module ibfd_track #(
  parameter int SAMPLE_BITS = 18,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ibfd_pkg::ibfd_trk_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  logic [SAMPLE_BITS-1:0]            seed_base,
  input  logic [SAMPLE_BITS-1:0]            seed_noise,
  output logic [SAMPLE_BITS+COUNT_BITS-1:0] level_sum,
  output logic [SAMPLE_BITS-1:0]            level_min,
  output logic [SAMPLE_BITS-1:0]            level_max,
  output logic [COUNT_BITS-1:0]             sample_total,
  output logic [SAMPLE_BITS-1:0]            tracked_level,
  output logic [SAMPLE_BITS-1:0]            noise_estimate
);

  import ibfd_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = {{(SAMPLE_BITS-1){1'b0}}, 1'b1};

  logic [SAMPLE_BITS-1:0] dev;
  logic                   dev_valid;

  logic                   base_ge;
  logic [SAMPLE_BITS-1:0] base_diff;
  logic [SAMPLE_BITS-1:0] base_step;
  logic [SAMPLE_BITS-1:0] base_follow;
  logic                   noise_ge;
  logic [SAMPLE_BITS-1:0] noise_diff;
  logic [SAMPLE_BITS-1:0] noise_step;
  logic [SAMPLE_BITS-1:0] noise_follow;
  logic [SAMPLE_BITS-1:0] noise_floor;
  logic                   count_full;

  // Baseline follower; the distance also serves as the deviation sample.
  assign base_ge     = (sample >= tracked_level);
  assign base_diff   = base_ge ? (sample - tracked_level) : (tracked_level - sample);
  assign base_step   = base_diff >> BASE_SHIFT;
  assign base_follow = base_ge ? (tracked_level + base_step) : (tracked_level - base_step);

  // Noise follower on the registered deviation, held at one or more.
  assign noise_ge     = (dev >= noise_estimate);
  assign noise_diff   = noise_ge ? (dev - noise_estimate) : (noise_estimate - dev);
  assign noise_step   = noise_diff >> NOISE_SHIFT;
  assign noise_follow = noise_ge ? (noise_estimate + noise_step)
                                 : (noise_estimate - noise_step);
  assign noise_floor  = (noise_follow == '0) ? SAMPLE_ONE : noise_follow;

  assign count_full = &sample_total;

  // Statistics and tracker state; a track update is followed by a noise step.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum      <= '0;
      level_min      <= '1;
      level_max      <= '0;
      sample_total   <= '0;
      tracked_level  <= '0;
      noise_estimate <= '0;
      dev_valid      <= 1'b0;
    end else if (ctl.update) begin
      dev_valid <= 1'b0;
      case (ctl.func)
        FUNC_CLEAR: begin
          level_sum      <= '0;
          level_min      <= '1;
          level_max      <= '0;
          sample_total   <= '0;
          tracked_level  <= '0;
          noise_estimate <= '0;
        end
        FUNC_CALIBRATE: begin
          // A full count ignores the sample so the statistics stay consistent.
          if (!count_full) begin
            level_sum    <= level_sum + SUM_BITS'(sample);
            sample_total <= sample_total + COUNT_BITS'(1);
            if (sample < level_min) begin
              level_min <= sample;
            end
            if (sample > level_max) begin
              level_max <= sample;
            end
          end
        end
        FUNC_SEED: begin
          tracked_level  <= seed_base;
          noise_estimate <= (seed_noise != '0) ? seed_noise : SAMPLE_ONE;
        end
        FUNC_TRACK: begin
          // An empty tracker takes the first sample as it is.
          if (tracked_level == '0) begin
            tracked_level  <= sample;
            noise_estimate <= SAMPLE_ONE;
          end else begin
            tracked_level <= base_follow;
            dev           <= base_diff;
            dev_valid     <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.noise_step && dev_valid) begin
      noise_estimate <= noise_floor;
      dev_valid      <= 1'b0;
    end
  end

endmodule

### sv/ir_baseline_finger_detector_top.sv
`timescale 1ns / 1ps

// IR baseline tracker and finger detector. Each input transaction carries a
// function code on tuser (clear, calibrate, seed, track, detect) and one
// result transaction comes back with the calibration average and range, the
// ready and stable flags, the effective baseline, the noise estimate and the
// finger state. One item is processed at a time: after acceptance the
// sequencer steps through update, a noise step for a track transaction only,
// divider start, divider wait and finish, and only then takes the next item.
// The wait is set by the bit-serial restoring divider that forms the average,
// one quotient bit per cycle over the full width of the running sum. Finish
// waits while the output register holds an undrained result; the register
// holds a finished result while the block goes back to accept the next item.

module ir_baseline_finger_detector_top #(
  parameter int SAMPLE_BITS = 18,
  parameter int COUNT_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ir_sample, seed_baseline, seed_noise, zero pad
  input  logic [ibfd_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // func
  input  logic [ibfd_pkg::FUNC_BITS-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // average_level, range_level, ready_flag, stable_flag, baseline_level,
  // noise_level, finger_present, zero pad
  output logic [ibfd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [ibfd_pkg::REG_IDX_BITS-1:0]  cfg_index,
  input  logic [ibfd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  import ibfd_pkg::*;

  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int WIDE_BITS = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam int CMP_BITS  = WIDE_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_NOISE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [TARGET_BITS-1:0]   target_count;
  logic [CFG_DATA_BITS-1:0] stable_limit;
  logic [CFG_DATA_BITS-1:0] on_delta;
  logic [CFG_DATA_BITS-1:0] off_delta;

  // Captured transaction.
  logic [FUNC_BITS-1:0]   func_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] seed_base_q;
  logic [SAMPLE_BITS-1:0] seed_noise_q;

  logic                   finger_state;
  logic [SAMPLE_BITS-1:0] range_q;
  logic [OUT_DATA_BITS-1:0] out_data;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic [SAMPLE_BITS-1:0] in_seed_base;
  logic [SAMPLE_BITS-1:0] in_seed_noise;

  ibfd_trk_ctl_t          trk_ctl;
  logic [SUM_BITS-1:0]    trk_sum;
  logic [SAMPLE_BITS-1:0] trk_min;
  logic [SAMPLE_BITS-1:0] trk_max;
  logic [COUNT_BITS-1:0]  trk_total;
  logic [SAMPLE_BITS-1:0] trk_tracked;
  logic [SAMPLE_BITS-1:0] trk_noise;

  logic                   div_start;
  logic                   div_done;
  logic [SUM_BITS-1:0]    div_quot;

  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] base;
  logic [SAMPLE_BITS-1:0] range_now;
  logic [CMP_BITS-1:0]    sample_cmp;
  logic [CMP_BITS-1:0]    on_thresh;
  logic [CMP_BITS-1:0]    off_thresh;
  logic                   finger_next;
  logic                   ready_flag;
  logic                   stable_flag;
  logic [FIELD_BITS-1:0]  avg_f;
  logic [FIELD_BITS-1:0]  range_f;
  logic [FIELD_BITS-1:0]  base_f;
  logic [FIELD_BITS-1:0]  noise_f;
  logic [OUT_DATA_BITS-1:0] out_pack;

  // Unpack the input fields to the internal sample width.
  assign in_sample     = SAMPLE_BITS'(WIDE_BITS'(s_axis_tdata[FIELD_BITS-1:0]));
  assign in_seed_base  = SAMPLE_BITS'(WIDE_BITS'(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]));
  assign in_seed_noise = SAMPLE_BITS'(WIDE_BITS'(s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]));

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer decodes.
  assign trk_ctl.update     = (state == ST_UPDATE);
  assign trk_ctl.noise_step = (state == ST_NOISE);
  assign trk_ctl.func       = func_q;
  assign div_start          = (state == ST_DIV_START);

  ibfd_track #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .ctl            (trk_ctl),
    .sample         (sample_q),
    .seed_base      (seed_base_q),
    .seed_noise     (seed_noise_q),
    .level_sum      (trk_sum),
    .level_min      (trk_min),
    .level_max      (trk_max),
    .sample_total   (trk_total),
    .tracked_level  (trk_tracked),
    .noise_estimate (trk_noise)
  );

  ibfd_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trk_sum),
    .divisor  (trk_total),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Calibration range, registered while the divider starts.
  assign range_now = ((trk_total != '0) && (trk_max >= trk_min)) ? (trk_max - trk_min) : '0;

  // Average, effective baseline and hysteresis thresholds.
  assign avg        = (trk_total != '0) ? div_quot[SAMPLE_BITS-1:0] : '0;
  assign base       = (trk_tracked != '0) ? trk_tracked : avg;
  assign sample_cmp = CMP_BITS'(sample_q);
  assign on_thresh  = CMP_BITS'(base) + CMP_BITS'(on_delta);
  assign off_thresh = CMP_BITS'(base) + CMP_BITS'(off_delta);

  always_comb begin
    finger_next = finger_state;
    if (func_q == FUNC_DETECT) begin
      if (!finger_state) begin
        finger_next = (sample_cmp > on_thresh);
      end else begin
        finger_next = !(sample_cmp < off_thresh);
      end
    end
  end

  assign ready_flag  = (TARGET_BITS'(trk_total) >= target_count);
  assign stable_flag = (trk_total != '0) &&
                       (WIDE_BITS'(range_q) <= WIDE_BITS'(stable_limit));

  // Result fields at the port width.
  assign avg_f   = FIELD_BITS'(WIDE_BITS'(avg));
  assign range_f = FIELD_BITS'(WIDE_BITS'(range_q));
  assign base_f  = FIELD_BITS'(WIDE_BITS'(base));
  assign noise_f = FIELD_BITS'(WIDE_BITS'(trk_noise));

  assign out_pack = {{OUT_PAD_BITS{1'b0}}, finger_next, noise_f, base_f,
                     stable_flag, ready_flag, range_f, avg_f};

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      finger_state  <= 1'b0;
      target_count  <= TARGET_COUNT_RESET;
      stable_limit  <= STABLE_LIMIT_RESET;
      on_delta      <= ON_DELTA_RESET;
      off_delta     <= OFF_DELTA_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_COUNT: target_count <= cfg_data[TARGET_BITS-1:0];
          REG_STABLE_LIMIT: stable_limit <= cfg_data;
          REG_ON_DELTA:     on_delta     <= cfg_data;
          REG_OFF_DELTA:    off_delta    <= cfg_data;
          default: begin
          end
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q       <= s_axis_tuser;
            sample_q     <= in_sample;
            seed_base_q  <= in_seed_base;
            seed_noise_q <= in_seed_noise;
            state        <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= (func_q == FUNC_TRACK) ? ST_NOISE : ST_DIV_START;
        end
        ST_NOISE: begin
          state <= ST_DIV_START;
        end
        ST_DIV_START: begin
          range_q <= range_now;
          state   <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Load the result once the output register is free or being drained.
          if (!m_axis_tvalid || m_axis_tready) begin
            out_data      <= out_pack;
            m_axis_tvalid <= 1'b1;
            finger_state  <= finger_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = out_data;

`ifndef SYNTH
  // Only one item is in flight: an acceptance closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // A new result appears only from the finishing step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result appeared outside the finishing step");

  // With any calibration sample in, the minimum never exceeds the maximum.
  assert property (@(posedge clk) disable iff (rst)
    (trk_total != '0) |-> (trk_min <= trk_max))
    else $error("calibration minimum above maximum");
`endif

endmodule
